>>> rtl/binary_to_decimal_ascii_defines.svh
// Assertion macros for the RTL.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge once reset has been released.
`define BTDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Also checked while reset is held.
`define BTDA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define BTDA_ASSERT(lbl, prop, msg)
`define BTDA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/btda_pkg.sv
package btda_pkg;

  localparam int unsigned NUM_BITS   = 64;
  localparam int unsigned NUM_DIGITS = 20;   // decimal digits of the largest 64-bit value
  localparam int unsigned BCD_W      = NUM_DIGITS * 4;
  localparam int unsigned CNT_W      = $clog2(NUM_BITS);
  localparam int unsigned LEFT_W     = 5;
  localparam int unsigned MAX_DIGITS = 16;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // Finished BCD word handed from the converter to the character sequencer.
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } conv_t;

endpackage

>>> rtl/btda_dabble.sv
// Shift-and-add-3 binary to BCD, one input bit per cycle.
module btda_dabble (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic                          neg_i,
  input  logic [btda_pkg::NUM_BITS-1:0] mag_i,
  output logic                          busy_o,
  output btda_pkg::conv_t               conv_o
);

  logic [btda_pkg::NUM_BITS-1:0] bin_q;
  logic [btda_pkg::BCD_W-1:0]    bcd_q;
  logic [btda_pkg::BCD_W-1:0]    adj;
  logic [btda_pkg::CNT_W-1:0]    cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic                          neg_q;

  // every digit of 5 or more gets +3 before the shift
  always_comb begin
    for (int i = 0; i < int'(btda_pkg::NUM_DIGITS); i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (load_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == {btda_pkg::CNT_W{1'b1}}) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bin_q <= mag_i;
      bcd_q <= '0;
      neg_q <= neg_i;
    end else if (busy_q) begin
      bin_q <= {bin_q[btda_pkg::NUM_BITS-2:0], 1'b0};
      bcd_q <= {adj[btda_pkg::BCD_W-2:0], bin_q[btda_pkg::NUM_BITS-1]};
    end
  end

  // stay busy through the hand-off cycle
  assign busy_o       = busy_q || done_q;
  assign conv_o.valid = done_q;
  assign conv_o.neg   = neg_q;
  assign conv_o.bcd   = bcd_q;

endmodule

>>> rtl/btda_emit.sv
`include "binary_to_decimal_ascii_defines.svh"

// Drops leading zero digits, checks the digit limit, then sends one character per cycle.
module btda_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  btda_pkg::conv_t conv_i,
  output logic            busy_o,
  output logic            strobe_o,
  output logic [7:0]      char_out_o,
  output logic            last_o,
  output logic            too_long_o
);

  localparam logic [btda_pkg::LEFT_W-1:0] LEFT_INIT = btda_pkg::LEFT_W'(btda_pkg::NUM_DIGITS);
  localparam logic [btda_pkg::LEFT_W-1:0] LEFT_MAX  = btda_pkg::LEFT_W'(btda_pkg::MAX_DIGITS);
  localparam logic [btda_pkg::LEFT_W-1:0] LEFT_ONE  = btda_pkg::LEFT_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SKIP,
    ST_DIGIT
  } state_e;

  state_e                      state_q;
  logic [btda_pkg::BCD_W-1:0]  dig_q;
  logic [btda_pkg::LEFT_W-1:0] left_q;
  logic                        neg_q;
  logic                        strobe_q;
  logic [7:0]                  char_q;
  logic                        last_q;
  logic                        err_q;
  logic [3:0]                  top;

  assign top = dig_q[btda_pkg::BCD_W-1 -: 4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      left_q   <= '0;
      char_q   <= '0;
      last_q   <= 1'b0;
      err_q    <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (conv_i.valid) begin
            left_q  <= LEFT_INIT;
            state_q <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // a zero value keeps its last digit
          if (top == 4'd0 && left_q > LEFT_ONE) begin
            left_q <= left_q - 1'b1;
          end else if (left_q > LEFT_MAX) begin
            strobe_q <= 1'b1;
            char_q   <= '0;
            last_q   <= 1'b1;
            err_q    <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            if (neg_q) begin
              strobe_q <= 1'b1;
              char_q   <= btda_pkg::ASCII_MINUS;
              last_q   <= 1'b0;
              err_q    <= 1'b0;
            end
            state_q <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          strobe_q <= 1'b1;
          char_q   <= btda_pkg::ASCII_ZERO + {4'd0, top};
          last_q   <= (left_q == LEFT_ONE);
          err_q    <= 1'b0;
          left_q   <= left_q - 1'b1;
          if (left_q == LEFT_ONE) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // digit shift register, top digit first
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && conv_i.valid) begin
      dig_q <= conv_i.bcd;
      neg_q <= conv_i.neg;
    end else if ((state_q == ST_SKIP && top == 4'd0 && left_q > LEFT_ONE) ||
                 state_q == ST_DIGIT) begin
      dig_q <= {dig_q[btda_pkg::BCD_W-5:0], 4'd0};
    end
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign strobe_o   = strobe_q;
  assign char_out_o = char_q;
  assign last_o     = last_q;
  assign too_long_o = err_q;

  `BTDA_ASSERT(a_err_is_last, strobe_q && err_q |-> last_q && char_q == 8'd0, "error word not alone")
  `BTDA_ASSERT(a_load_when_idle, conv_i.valid |-> state_q == ST_IDLE, "BCD word while busy")
  `BTDA_ASSERT(a_gap_after_last, strobe_q && last_q |=> !strobe_q, "word after last")
  `BTDA_ASSERT(a_digit_bcd, state_q == ST_DIGIT |-> top <= 4'd9 && left_q != 0, "bad digit")
  `BTDA_ASSERT_ALWAYS(a_no_strobe_reset, !rst_ni |=> !strobe_o, "strobe after reset")

endmodule

>>> rtl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter.
// Input: pulse start_i with value_bits_i and is_signed_i while busy_o is low; the number is
// taken at that clock edge. is_signed_i reads value_bits_i as two's complement.
// Output: each character word is on char_out_o/last_o/too_long_o for one cycle with
// strobe_o high: an optional '-', then the decimal digits, most significant first, no
// leading zeros; last_o marks the final one. A magnitude with more than 16 digits gives
// one word with too_long_o and last_o set and char_out_o zero, and no characters.
// Flow: the magnitude goes through a one-bit-per-cycle shift-add-3 converter, then a
// digit shift register drops up to 19 leading zeros, one per cycle, and sends one
// character per cycle. A new number is taken only while busy_o is low, so each number
// is converted and sent in full before the next one is taken.
// busy_o stays high until the final word is being shown.
// The receiver cannot stall: words are shown once and not held.
// Reset clears the control state; an item in flight is dropped and busy_o falls.
module binary_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] value_bits_i,
  input  logic        is_signed_i,
  output logic        strobe_o,
  output logic [7:0]  char_out_o,
  output logic        last_o,
  output logic        too_long_o
);

  logic                          accept;
  logic                          neg;
  logic [btda_pkg::NUM_BITS-1:0] mag;
  logic                          conv_busy;
  logic                          emit_busy;
  btda_pkg::conv_t               conv;

  assign accept = start_i && !busy_o;
  assign neg    = is_signed_i && value_bits_i[63];
  assign mag    = neg ? (~value_bits_i + 64'd1) : value_bits_i;
  assign busy_o = conv_busy || emit_busy;

  btda_dabble u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .neg_i  (neg),
    .mag_i  (mag),
    .busy_o (conv_busy),
    .conv_o (conv)
  );

  btda_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .conv_i     (conv),
    .busy_o     (emit_busy),
    .strobe_o   (strobe_o),
    .char_out_o (char_out_o),
    .last_o     (last_o),
    .too_long_o (too_long_o)
  );

endmodule
